[rtl/core/pec_pkg.sv]
`default_nettype none
package pec_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int TIME_BITS_DEF = 16;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	localparam logic [1:0] REG_CURVE_SELECT = 2'd0;
	localparam logic [1:0] REG_START_VALUE = 2'd1;
	localparam logic [1:0] REG_CHANGE_VALUE = 2'd2;
	localparam logic [1:0] REG_DURATION = 2'd3;

	localparam int CURVE_W = 5;
	localparam int DUR_W_MAX = 16;

	typedef struct packed {
		logic [CURVE_W-1:0] curve_select;
		logic signed [31:0] start_value;
		logic signed [31:0] change_value;
	} pec_cfg_t;

	typedef struct packed {
		logic signed [31:0] eased_value;
		logic saturated;
	} pec_res_t;

endpackage
`default_nettype wire

[rtl/core/pec_div.sv]
`default_nettype none
module pec_div #(
	parameter int FRACTION_BITS = pec_pkg::FRACTION_BITS_DEF,
	parameter int TIME_BITS = pec_pkg::TIME_BITS_DEF,
	parameter int DUR_W = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_vld,
	input wire logic [TIME_BITS-1:0] t_in,
	input wire logic [DUR_W-1:0] dur,
	output logic out_vld,
	output logic [FRACTION_BITS:0] u_out
);
	localparam int F = FRACTION_BITS;
	localparam int TB = TIME_BITS;

	logic [TB-1:0] rem_s [0:F];
	logic [F:0] quo_s [0:F];
	logic vld_s [0:F];

	logic [TB-1:0] dur_t;
	logic [TB-1:0] t_clamp;
	logic q_top;

	// t is clamped to d, so the top quotient bit is set only when t reaches or exceeds d
	always_comb begin
		dur_t = TB'(dur);
		t_clamp = (t_in > dur_t) ? dur_t : t_in;
		q_top = (t_clamp == dur_t);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= q_top ? '0 : t_clamp;
			quo_s[0] <= (F+1)'(q_top);
		end
	end

	for (genvar i = 1; i <= F; i++) begin : g_stage
		logic [TB:0] rem2;
		logic [TB:0] dur_x;
		logic ge;

		always_comb begin
			rem2 = {rem_s[i-1], 1'b0};
			dur_x = (TB+1)'(dur);
			ge = (rem2 >= dur_x);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? TB'(rem2 - dur_x) : TB'(rem2);
				quo_s[i] <= {quo_s[i-1][F-1:0], ge};
			end
		end
	end

	// zero duration means the motion is complete
	assign u_out = (dur == '0) ? {1'b1, {F{1'b0}}} : quo_s[F];
	assign out_vld = vld_s[F];

endmodule
`default_nettype wire

[rtl/core/pec_eval.sv]
`default_nettype none
module pec_eval #(
	parameter int FRACTION_BITS = pec_pkg::FRACTION_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_vld,
	input wire logic [FRACTION_BITS:0] u_in,
	input wire pec_pkg::pec_cfg_t cfg,
	output logic out_vld,
	output pec_pkg::pec_res_t res
);
	localparam int F = FRACTION_BITS;
	localparam int W = F + 6;
	localparam int PW = 32 + W;
	localparam int RW = PW - F;
	localparam int SW = RW + 2;

	localparam longint ONE_L = longint'(1) << F;
	localparam longint SB1_L = ((longint'(170158) << F) * 2 + 100000) / 200000;
	localparam longint SB2_L = ((longint'(25949095) << F) * 2 + 10000000) / 20000000;
	localparam longint KB_L = 121 * ONE_L / 16;
	localparam longint O1_L = (12 * ONE_L + 11) / 22;
	localparam longint O2_L = (18 * ONE_L + 11) / 22;
	localparam longint O3_L = (42 * ONE_L + 22) / 44;
	localparam longint A1_L = 3 * ONE_L / 4;
	localparam longint A2_L = 15 * ONE_L / 16;
	localparam longint A3_L = 63 * ONE_L / 64;

	localparam logic signed [W-1:0] ONE = W'(ONE_L);
	localparam logic signed [W-1:0] SB1 = W'(SB1_L);
	localparam logic signed [W-1:0] SB2 = W'(SB2_L);
	localparam logic signed [W-1:0] KB = W'(KB_L);
	localparam logic signed [W-1:0] BO1 = W'(O1_L);
	localparam logic signed [W-1:0] BO2 = W'(O2_L);
	localparam logic signed [W-1:0] BO3 = W'(O3_L);
	localparam logic signed [W-1:0] BA1 = W'(A1_L);
	localparam logic signed [W-1:0] BA2 = W'(A2_L);
	localparam logic signed [W-1:0] BA3 = W'(A3_L);
	localparam logic signed [W-1:0] LIM4 = W'(4 * ONE_L);
	localparam logic signed [W-1:0] LIM8 = W'(8 * ONE_L);
	localparam logic signed [W-1:0] LIM10 = W'(10 * ONE_L);
	localparam logic signed [W-1:0] THREE = W'(3 * ONE_L);
	localparam logic signed [W-1:0] TEN = W'(10 * ONE_L);
	localparam logic signed [W-1:0] FIFTEEN = W'(15 * ONE_L);
	localparam logic [2*W-1:0] RND_W = (2*W)'(1) << (F - 1);
	localparam logic [PW-1:0] RND_P = PW'(1) << (F - 1);
	localparam logic signed [SW-1:0] MAX_I = SW'(64'sd2147483647);
	localparam logic signed [SW-1:0] MIN_I = -SW'(64'sd2147483648);

	localparam logic [4:0] SEL_SMOOTH = 5'd1;
	localparam logic [4:0] SEL_SMOOTHER = 5'd2;
	localparam logic [4:0] SEL_FIRST = 5'd3;
	localparam logic [4:0] SEL_LAST = 5'd26;
	localparam logic [2:0] FAM_QUAD = 3'd0;
	localparam logic [2:0] FAM_CUBIC = 3'd1;
	localparam logic [2:0] FAM_QUART = 3'd2;
	localparam logic [2:0] FAM_QUINT = 3'd3;
	localparam logic [2:0] FAM_BACK = 3'd4;
	localparam logic [2:0] FAM_BOUNCE = 3'd5;
	localparam logic [1:0] V_IN = 2'd0;
	localparam logic [1:0] V_OUT = 2'd1;
	localparam logic [1:0] V_INOUT = 2'd2;
	localparam logic [1:0] V_OUTIN = 2'd3;

	typedef enum logic [3:0] {
		K_LIN, K_SS, K_SSS, K_QUAD, K_CUBIC, K_QUART, K_QUINT, K_BACK, K_BOUNCE
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic neg;
		logic half;
	} ctl_t;

	// product of two Q.F values, rounded half away from zero
	function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic [W-1:0] ma;
		logic [W-1:0] mb;
		logic [2*W-1:0] p;
		logic [2*W-1:0] r;
		ma = a[W-1] ? W'(-a) : W'(a);
		mb = b[W-1] ? W'(-b) : W'(b);
		p = {{W{1'b0}}, ma} * {{W{1'b0}}, mb};
		r = (p + RND_W) >> F;
		return (a[W-1] ^ b[W-1]) ? -$signed(r[W-1:0]) : $signed(r[W-1:0]);
	endfunction

	function automatic logic signed [W-1:0] qhalf(input logic signed [W-1:0] a);
		logic [W-1:0] m;
		logic [W-1:0] r;
		m = a[W-1] ? W'(-a) : W'(a);
		r = (m + W'(1)) >> 1;
		return a[W-1] ? -$signed(r) : $signed(r);
	endfunction

	// curve decode: map every variant onto g(y) with f = a +/- g, maybe halved
	logic [4:0] code;
	logic [2:0] fam;
	logic [1:0] vnt;
	logic signed [W-1:0] u_w;
	logic signed [W-1:0] x_d;
	logic signed [W-1:0] base_d;
	logic signed [W-1:0] y_d;
	logic signed [W-1:0] a_d;
	logic signed [W-1:0] sb_d;
	logic qform;
	logic comp;
	logic low;
	ctl_t ctl_d;

	always_comb begin
		code = cfg.curve_select - SEL_FIRST;
		fam = code[4:2];
		vnt = code[1:0];
		u_w = $signed(W'(u_in));
		low = (u_in[F:F-1] == 2'b00);
		x_d = u_w;
		base_d = '0;
		qform = 1'b0;
		comp = 1'b0;
		y_d = u_w;
		a_d = '0;
		sb_d = SB1;
		ctl_d.kind = K_LIN;
		ctl_d.neg = 1'b0;
		ctl_d.half = 1'b0;
		if (cfg.curve_select == SEL_SMOOTH) begin
			ctl_d.kind = K_SS;
		end else if (cfg.curve_select == SEL_SMOOTHER) begin
			ctl_d.kind = K_SSS;
		end else if (cfg.curve_select >= SEL_FIRST && cfg.curve_select <= SEL_LAST) begin
			unique case (fam)
				FAM_QUAD: ctl_d.kind = K_QUAD;
				FAM_CUBIC: ctl_d.kind = K_CUBIC;
				FAM_QUART: ctl_d.kind = K_QUART;
				FAM_QUINT: ctl_d.kind = K_QUINT;
				FAM_BACK: ctl_d.kind = K_BACK;
				FAM_BOUNCE: ctl_d.kind = K_BOUNCE;
				default: ctl_d.kind = K_LIN;
			endcase
			unique case (vnt)
				V_IN: begin
					qform = 1'b0;
				end
				V_OUT: begin
					qform = 1'b1;
				end
				V_INOUT: begin
					ctl_d.half = 1'b1;
					if (low) begin
						x_d = u_w <<< 1;
					end else begin
						x_d = (u_w <<< 1) - ONE;
						base_d = ONE;
						qform = 1'b1;
					end
				end
				default: begin
					ctl_d.half = 1'b1;
					if (low) begin
						x_d = u_w <<< 1;
						qform = 1'b1;
					end else begin
						x_d = (u_w <<< 1) - ONE;
						base_d = ONE;
					end
				end
			endcase
			// bounce evaluates its out curve directly
			comp = qform ^ (fam == FAM_BOUNCE);
			y_d = comp ? ONE - x_d : x_d;
			a_d = comp ? base_d + ONE : base_d;
			ctl_d.neg = comp;
			sb_d = (fam == FAM_BACK && vnt == V_INOUT) ? SB2 : SB1;
		end
	end

	// stage 1
	logic vld_s1;
	ctl_t ctl_s1;
	logic signed [W-1:0] y_s1;
	logic signed [W-1:0] a_s1;
	logic signed [W-1:0] sb_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl_d;
			y_s1 <= y_d;
			a_s1 <= a_d;
			sb_s1 <= sb_d;
		end
	end

	logic signed [W-1:0] y11;
	logic signed [W-1:0] ob1;
	logic signed [W-1:0] ob2;
	logic signed [W-1:0] badd_1;
	logic signed [W-1:0] e1;

	always_comb begin
		y11 = (y_s1 <<< 3) + (y_s1 <<< 1) + y_s1;
		priority if (y11 < LIM4) begin
			e1 = y_s1;
			badd_1 = '0;
		end else if (y11 < LIM8) begin
			e1 = y_s1 - BO1;
			badd_1 = BA1;
		end else if (y11 < LIM10) begin
			e1 = y_s1 - BO2;
			badd_1 = BA2;
		end else begin
			e1 = y_s1 - BO3;
			badd_1 = BA3;
		end
		ob1 = '0;
		ob2 = '0;
		unique case (ctl_s1.kind)
			K_BACK: begin
				ob1 = sb_s1 + ONE;
				ob2 = y_s1;
			end
			K_BOUNCE: begin
				ob1 = e1;
				ob2 = e1;
			end
			K_SSS: begin
				ob1 = y_s1;
				ob2 = (y_s1 <<< 2) + (y_s1 <<< 1) - FIFTEEN;
			end
			default: begin
				ob1 = '0;
				ob2 = '0;
			end
		endcase
	end

	// stage 2: square and first side product
	logic vld_s2;
	ctl_t ctl_s2;
	logic signed [W-1:0] y_s2;
	logic signed [W-1:0] y2_s2;
	logic signed [W-1:0] b_s2;
	logic signed [W-1:0] a_s2;
	logic signed [W-1:0] sb_s2;
	logic signed [W-1:0] badd_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2 <= ctl_s1;
			y_s2 <= y_s1;
			y2_s2 <= qmul(y_s1, y_s1);
			b_s2 <= qmul(ob1, ob2);
			a_s2 <= a_s1;
			sb_s2 <= sb_s1;
			badd_s2 <= badd_1;
		end
	end

	logic signed [W-1:0] mb1;
	logic signed [W-1:0] mb2;

	always_comb begin
		unique case (ctl_s2.kind)
			K_BACK: begin
				mb1 = y2_s2;
				mb2 = b_s2 - sb_s2;
			end
			K_BOUNCE: begin
				mb1 = KB;
				mb2 = b_s2;
			end
			K_SS: begin
				mb1 = y2_s2;
				mb2 = THREE - (y_s2 <<< 1);
			end
			default: begin
				mb1 = '0;
				mb2 = '0;
			end
		endcase
	end

	// stage 3
	logic vld_s3;
	ctl_t ctl_s3;
	logic signed [W-1:0] y_s3;
	logic signed [W-1:0] y2_s3;
	logic signed [W-1:0] y3_s3;
	logic signed [W-1:0] b_s3;
	logic signed [W-1:0] c_s3;
	logic signed [W-1:0] a_s3;
	logic signed [W-1:0] badd_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s3 <= ctl_s2;
			y_s3 <= y_s2;
			y2_s3 <= y2_s2;
			y3_s3 <= qmul(y2_s2, y_s2);
			b_s3 <= qmul(mb1, mb2);
			c_s3 <= b_s2 + TEN;
			a_s3 <= a_s2;
			badd_s3 <= badd_s2;
		end
	end

	// stage 4
	logic vld_s4;
	ctl_t ctl_s4;
	logic signed [W-1:0] y_s4;
	logic signed [W-1:0] y2_s4;
	logic signed [W-1:0] y3_s4;
	logic signed [W-1:0] y4_s4;
	logic signed [W-1:0] b_s4;
	logic signed [W-1:0] a_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s4 <= ctl_s3;
			y_s4 <= y_s3;
			y2_s4 <= y2_s3;
			y3_s4 <= y3_s3;
			y4_s4 <= qmul(y3_s3, y_s3);
			unique case (ctl_s3.kind)
				K_SSS: b_s4 <= qmul(y3_s3, c_s3);
				K_BOUNCE: b_s4 <= b_s3 + badd_s3;
				default: b_s4 <= b_s3;
			endcase
			a_s4 <= a_s3;
		end
	end

	logic signed [W-1:0] g_pre;

	always_comb begin
		unique case (ctl_s4.kind)
			K_LIN: g_pre = y_s4;
			K_QUAD: g_pre = y2_s4;
			K_CUBIC: g_pre = y3_s4;
			K_QUART: g_pre = y4_s4;
			default: g_pre = b_s4;
		endcase
	end

	// stage 5: curve core value
	logic vld_s5;
	ctl_t ctl_s5;
	logic signed [W-1:0] g_s5;
	logic signed [W-1:0] a_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s5 <= ctl_s4;
			g_s5 <= (ctl_s4.kind == K_QUINT) ? qmul(y4_s4, y_s4) : g_pre;
			a_s5 <= a_s4;
		end
	end

	logic signed [W-1:0] v5;

	assign v5 = ctl_s5.neg ? a_s5 - g_s5 : a_s5 + g_s5;

	// stage 6: curve value f
	logic vld_s6;
	logic signed [W-1:0] f_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			f_s6 <= ctl_s5.half ? qhalf(v5) : v5;
		end
	end

	logic [31:0] mc;
	logic [W-1:0] mf;

	always_comb begin
		mc = cfg.change_value[31] ? 32'(-cfg.change_value) : 32'(cfg.change_value);
		mf = f_s6[W-1] ? W'(-f_s6) : W'(f_s6);
	end

	// stage 7: scale by change
	logic vld_s7;
	logic [PW-1:0] p_s7;
	logic neg_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s7 <= {{W{1'b0}}, mc} * {{32{1'b0}}, mf};
			neg_s7 <= cfg.change_value[31] ^ f_s6[W-1];
		end
	end

	logic [PW-1:0] r_full;
	logic signed [SW-1:0] r_s;
	logic signed [SW-1:0] sum7;

	always_comb begin
		r_full = (p_s7 + RND_P) >> F;
		r_s = $signed({2'b00, r_full[RW-1:0]});
		sum7 = {{(SW-32){cfg.start_value[31]}}, cfg.start_value} + (neg_s7 ? -r_s : r_s);
	end

	// stage 8: offset and saturate
	logic vld_s8;
	pec_pkg::pec_res_t res_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (sum7 > MAX_I) begin
				res_s8.eased_value <= 32'sh7fffffff;
				res_s8.saturated <= 1'b1;
			end else if (sum7 < MIN_I) begin
				res_s8.eased_value <= 32'sh80000000;
				res_s8.saturated <= 1'b1;
			end else begin
				res_s8.eased_value <= sum7[31:0];
				res_s8.saturated <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	assign out_vld = vld_s8;
	assign res = res_s8;

endmodule
`default_nettype wire

[rtl/core/polynomial_easing_curve.sv]
`default_nettype none
// channel   | signals                                      | transfer when
// ----------+----------------------------------------------+-----------------------------
// item      | item_valid, item_ready, elapsed_time         | item_valid & item_ready
// result    | result_valid, result_ready, eased_value,     | result_valid & result_ready
//           | saturated                                    |
// config    | psel, penable, pwrite, paddr, pwdata, prdata | psel & penable & pwrite
//
// one item per cycle while item_ready is high; u is formed by the one-bit-per-stage divider,
// then passes the eight-stage curve and scale pipeline and the output register.
// reset clears all valid bits and loads the register reset values; nothing else to clear.
// a two-entry output buffer lets one more transfer in while a result waits; after that
// the whole pipeline holds until result_ready returns, with nothing lost or repeated.
module polynomial_easing_curve #(
	parameter int FRACTION_BITS = pec_pkg::FRACTION_BITS_DEF,
	parameter int TIME_BITS = pec_pkg::TIME_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [pec_pkg::APB_AW-1:0] paddr,
	input wire logic [pec_pkg::APB_DW-1:0] pwdata,
	output logic [pec_pkg::APB_DW-1:0] prdata,
	output logic pready,
	input wire logic item_valid,
	output logic item_ready,
	input wire logic [TIME_BITS-1:0] elapsed_time,
	output logic result_valid,
	input wire logic result_ready,
	output logic signed [31:0] eased_value,
	output logic saturated
);
	localparam int DUR_W = (TIME_BITS < pec_pkg::DUR_W_MAX) ? TIME_BITS : pec_pkg::DUR_W_MAX;

	logic [pec_pkg::CURVE_W-1:0] curve_q;
	logic signed [31:0] start_q;
	logic signed [31:0] change_q;
	logic [DUR_W-1:0] duration_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_q <= '0;
			start_q <= '0;
			change_q <= '0;
			duration_q <= DUR_W'(1);
		end else if (wr) begin
			unique case (paddr[3:2])
				pec_pkg::REG_CURVE_SELECT: curve_q <= pwdata[pec_pkg::CURVE_W-1:0];
				pec_pkg::REG_START_VALUE: start_q <= pwdata;
				pec_pkg::REG_CHANGE_VALUE: change_q <= pwdata;
				default: duration_q <= pwdata[DUR_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			pec_pkg::REG_CURVE_SELECT: prdata = pec_pkg::APB_DW'(curve_q);
			pec_pkg::REG_START_VALUE: prdata = start_q;
			pec_pkg::REG_CHANGE_VALUE: prdata = change_q;
			default: prdata = pec_pkg::APB_DW'(duration_q);
		endcase
	end

	pec_pkg::pec_cfg_t cfg;

	assign cfg.curve_select = curve_q;
	assign cfg.start_value = start_q;
	assign cfg.change_value = change_q;

	logic en;
	logic skid_valid_q;
	logic div_vld;
	logic [FRACTION_BITS:0] div_u;
	logic pipe_vld;
	pec_pkg::pec_res_t pipe_res;

	assign en = !skid_valid_q;
	assign item_ready = en;

	pec_div #(
		.FRACTION_BITS(FRACTION_BITS),
		.TIME_BITS(TIME_BITS),
		.DUR_W(DUR_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(item_valid),
		.t_in(elapsed_time),
		.dur(duration_q),
		.out_vld(div_vld),
		.u_out(div_u)
	);

	pec_eval #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_eval (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(div_vld),
		.u_in(div_u),
		.cfg(cfg),
		.out_vld(pipe_vld),
		.res(pipe_res)
	);

	// output register plus skid entry
	logic out_valid_q;
	pec_pkg::pec_res_t out_q;
	pec_pkg::pec_res_t skid_q;
	logic push;
	logic out_free;

	assign push = en & pipe_vld;
	assign out_free = !out_valid_q | result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= push;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= pipe_res;
				end
			end else if (push) begin
				out_q <= pipe_res;
			end
		end else if (push) begin
			skid_q <= pipe_res;
		end
	end

	assign result_valid = out_valid_q;
	assign eased_value = out_q.eased_value;
	assign saturated = out_q.saturated;

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated |->
			eased_value == 32'sh7fffffff || eased_value == 32'sh80000000)
		else $error("saturated result not at a limit");

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !result_ready))
		else $error("skid filled without an output stall");

endmodule
`default_nettype wire
